>>> rtl/hbs_rlwd_pkg.sv
// shared constants and controller/datapath interface types for the run-length word decoder
`timescale 1ns / 1ps

package hbs_rlwd_pkg;

    // packet store capacity in words
    localparam int MAX_WORDS = 32;
    localparam int WCNT_W    = $clog2(MAX_WORDS + 1);

    // field widths fixed by the interface
    localparam int TICK_W    = 15;
    localparam int QUO_W     = TICK_W + 1;
    localparam int STEP_W    = $clog2(QUO_W);
    localparam int SHIFT_W   = 20;
    localparam int BCNT_W    = 5;
    localparam int WIDX_W    = 5;
    localparam int PWORDS_W  = 6;

    // a word holds 21 bit times; a zero run or one that would pass them closes it
    localparam logic [BCNT_W-1:0] LAST_BIT  = 5'd21;
    localparam logic [QUO_W-1:0]  START_LIM = 16'd22;
    localparam logic [TICK_W-1:0] DIV_RESET = 15'd104;

    // configuration register indexes
    localparam logic CFG_BIT_DIVIDER  = 1'b0;
    localparam logic CFG_INVERT_LEVEL = 1'b1;

    typedef struct packed {
        logic load;     // capture the input transfer and start the divide
        logic step;     // one restoring divide step
        logic commit;   // update decoder state and load the result register
    } t_cmd;

    typedef struct packed {
        logic div_last; // current divide step is the final one
        logic out_free; // result register can take a new result
    } t_sts;

endpackage

>>> rtl/hbs_rlwd_ctrl.sv
// sequencing state machine: capture, iterative divide, commit
`timescale 1ns / 1ps

module hbs_rlwd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hbs_rlwd_pkg::t_sts  i_sts,
    output hbs_rlwd_pkg::t_cmd  o_cmd
);
    import hbs_rlwd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait here only while a previous result is still stalled
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/hbs_rlwd_dp.sv
// datapath: config registers, run divider, shift word, counters and result register
`timescale 1ns / 1ps

module hbs_rlwd_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  hbs_rlwd_pkg::t_cmd                   i_cmd,
    output hbs_rlwd_pkg::t_sts                   o_sts,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_index,
    input  logic [hbs_rlwd_pkg::TICK_W-1:0]      i_cfg_data,
    input  logic                                 i_line_level,
    input  logic [hbs_rlwd_pkg::TICK_W-1:0]      i_run_ticks,
    input  logic                                 i_end_of_capture,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_word_valid,
    output logic [7:0]                           o_data_byte,
    output logic                                 o_parity_flag,
    output logic [hbs_rlwd_pkg::WIDX_W-1:0]      o_word_index,
    output logic                                 o_start_error,
    output logic                                 o_packet_done,
    output logic [hbs_rlwd_pkg::PWORDS_W-1:0]    o_packet_words,
    output logic                                 o_overflow
);
    import hbs_rlwd_pkg::*;

    // configuration
    logic [TICK_W-1:0] r_bit_divider;
    logic              r_invert_level;
    logic [TICK_W-1:0] div_eff;

    // captured item and divider
    logic              r_lvl;
    logic              r_eoc;
    logic [QUO_W-1:0]  r_quo;
    logic [TICK_W-1:0] r_rem;
    logic [STEP_W-1:0] r_step;
    logic [QUO_W-1:0]  trial;
    logic              q_bit;

    // decoder state
    logic [SHIFT_W-1:0] r_shift_word;
    logic [BCNT_W-1:0]  r_bit_count;
    logic [WCNT_W-1:0]  r_word_count;
    logic               r_overflow_seen;

    // commit logic
    logic [QUO_W-1:0]       dur;
    logic                   idle;
    logic                   start_ok;
    logic [QUO_W:0]         end_sum;
    logic                   close;
    logic [BCNT_W-1:0]      n_shifts;
    logic [2*SHIFT_W-1:0]   shift_ext;
    logic [SHIFT_W-1:0]     shifted;
    logic                   store_ok;
    logic                   wv;
    logic                   drop;
    logic                   serr;
    logic                   emit;
    logic [7:0]             data;
    logic [SHIFT_W-1:0]     n_shift_word;
    logic [BCNT_W-1:0]      n_bit_count;
    logic [WCNT_W-1:0]      n_word_count;
    logic                   n_overflow_seen;
    logic [WCNT_W+WIDX_W-1:0]   widx_ext;
    logic [WCNT_W+PWORDS_W-1:0] pwords_ext;

    // result register
    logic                   r_out_valid;
    logic                   r_word_valid;
    logic [7:0]             r_data_byte;
    logic                   r_parity_flag;
    logic [WIDX_W-1:0]      r_word_index;
    logic                   r_start_error;
    logic                   r_packet_done;
    logic [PWORDS_W-1:0]    r_packet_words;
    logic                   r_overflow;

    assign div_eff = (r_bit_divider == '0) ? TICK_W'(1) : r_bit_divider;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_divider  <= DIV_RESET;
            r_invert_level <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BIT_DIVIDER:  r_bit_divider  <= i_cfg_data;
                CFG_INVERT_LEVEL: r_invert_level <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // restoring divide, one quotient bit per cycle, dividend shifts out of r_quo
    assign trial = {r_rem, r_quo[QUO_W-1]};
    assign q_bit = (trial >= {1'b0, div_eff});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lvl <= i_line_level ^ r_invert_level;
            r_eoc <= i_end_of_capture;
            // round to nearest bit time
            r_quo <= {1'b0, i_run_ticks} + {2'b00, div_eff[TICK_W-1:1]};
            r_rem <= '0;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[QUO_W-2:0], q_bit};
            r_rem <= q_bit ? TICK_W'(trial - {1'b0, div_eff}) : trial[TICK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.load) begin
            r_step <= '0;
        end else if (i_cmd.step) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    assign o_sts.div_last = (r_step == STEP_W'(QUO_W - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // decode of one run
    assign dur      = r_quo;
    assign idle     = (r_bit_count == '0);
    assign start_ok = !r_lvl && (dur != '0) && (dur < START_LIM);
    assign end_sum  = {{(QUO_W+1-BCNT_W){1'b0}}, r_bit_count} + {1'b0, dur};
    assign close    = !idle && ((dur == '0) || (end_sum > (QUO_W+1)'(LAST_BIT)));
    // pad up to the last bit time on close, otherwise one shift per bit time
    assign n_shifts  = close ? (LAST_BIT - r_bit_count) : dur[BCNT_W-1:0];
    assign shift_ext = {{SHIFT_W{r_lvl}}, r_shift_word} >> n_shifts;
    assign shifted   = shift_ext[SHIFT_W-1:0];
    assign store_ok  = (r_word_count < WCNT_W'(MAX_WORDS));
    assign wv        = close && store_ok;
    assign drop      = close && !store_ok;
    assign serr      = idle && !start_ok;
    assign emit      = serr || close || r_eoc;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            data[i] = shifted[2*i+1];
        end
    end

    always_comb begin
        n_shift_word    = r_shift_word;
        n_bit_count     = r_bit_count;
        if (idle) begin
            if (start_ok) begin
                n_shift_word = '0;
                n_bit_count  = dur[BCNT_W-1:0];
            end
        end else if (close) begin
            n_shift_word = shifted;
            n_bit_count  = '0;
        end else begin
            n_shift_word = shifted;
            n_bit_count  = r_bit_count + dur[BCNT_W-1:0];
        end
        n_word_count    = r_word_count + WCNT_W'(wv);
        n_overflow_seen = r_overflow_seen || drop;
    end

    assign widx_ext   = {{WIDX_W{1'b0}}, r_word_count};
    assign pwords_ext = {{PWORDS_W{1'b0}}, n_word_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_word    <= '0;
            r_bit_count     <= '0;
            r_word_count    <= '0;
            r_overflow_seen <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_eoc) begin
                // packet close clears everything, an open word is discarded
                r_shift_word    <= '0;
                r_bit_count     <= '0;
                r_word_count    <= '0;
                r_overflow_seen <= 1'b0;
            end else begin
                r_shift_word    <= n_shift_word;
                r_bit_count     <= n_bit_count;
                r_word_count    <= n_word_count;
                r_overflow_seen <= n_overflow_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && emit) begin
            r_word_valid   <= wv;
            r_data_byte    <= wv ? data : 8'd0;
            r_parity_flag  <= wv && shifted[17];
            r_word_index   <= wv ? widx_ext[WIDX_W-1:0] : '0;
            r_start_error  <= serr;
            r_packet_done  <= r_eoc;
            r_packet_words <= r_eoc ? pwords_ext[PWORDS_W-1:0] : '0;
            r_overflow     <= r_eoc ? n_overflow_seen : drop;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_word_valid   = r_word_valid;
    assign o_data_byte    = r_data_byte;
    assign o_parity_flag  = r_parity_flag;
    assign o_word_index   = r_word_index;
    assign o_start_error  = r_start_error;
    assign o_packet_done  = r_packet_done;
    assign o_packet_words = r_packet_words;
    assign o_overflow     = r_overflow;

endmodule

>>> rtl/hbs_run_length_word_decoder_top.sv
// top level of the run-length word decoder for a home-bus serial line
`timescale 1ns / 1ps

// Input channel: one transfer per captured line run (level, length in
// capture ticks, end-of-capture mark), taken when i_in_valid is high and
// o_in_stall is low. The run length is rounded to bit times by a restoring
// divider that produces one quotient bit per cycle; an item goes through
// capture, 16 divide steps and commit on its way to the result register.
// o_in_stall is low only between items; the next run waits for a commit.
// Output channel: at most one result per run, held in a result register
// until a transfer with i_out_stall low. While the receiver stalls, the
// next run is still taken and divided; its commit waits for the register.
// Runs that produce no result leave the output channel untouched.
// Configuration: index 0 is bit_divider (0 acts as 1), index 1 is
// invert_level; o_cfg_ready is always high and writes are applied at once.
// Reset (synchronous, active low) clears the decoder to waiting for a start
// bit, empties the packet, drops any pending result and restores the
// default configuration (divider 104, no inversion).

module hbs_run_length_word_decoder_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic                                 i_cfg_index,
    input  logic [hbs_rlwd_pkg::TICK_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_line_level,
    input  logic [hbs_rlwd_pkg::TICK_W-1:0]      i_run_ticks,
    input  logic                                 i_end_of_capture,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_word_valid,
    output logic [7:0]                           o_data_byte,
    output logic                                 o_parity_flag,
    output logic [hbs_rlwd_pkg::WIDX_W-1:0]      o_word_index,
    output logic                                 o_start_error,
    output logic                                 o_packet_done,
    output logic [hbs_rlwd_pkg::PWORDS_W-1:0]    o_packet_words,
    output logic                                 o_overflow
);
    import hbs_rlwd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    hbs_rlwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hbs_rlwd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_line_level     (i_line_level),
        .i_run_ticks      (i_run_ticks),
        .i_end_of_capture (i_end_of_capture),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_word_valid     (o_word_valid),
        .o_data_byte      (o_data_byte),
        .o_parity_flag    (o_parity_flag),
        .o_word_index     (o_word_index),
        .o_start_error    (o_start_error),
        .o_packet_done    (o_packet_done),
        .o_packet_words   (o_packet_words),
        .o_overflow       (o_overflow)
    );

    // a start error only happens while idle, a word only inside one
    a_word_xor_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_word_valid && o_start_error))
        else $error("word and start error in one result");

    // a full store never delivers a word
    a_word_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_word_valid |-> !o_overflow)
        else $error("word delivered together with overflow");

    a_count_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_packet_done |-> (o_packet_words == '0))
        else $error("packet word count outside packet close");

    // the divider is busy right after a transfer is taken
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in progress");

endmodule

>>> test/hbs_run_length_word_decoder_top_test.sv
// self-checking testbench for the run-length word decoder top level
`timescale 1ns / 1ps

module hbs_run_length_word_decoder_top_test;

    import hbs_rlwd_pkg::*;

    localparam int ITEM_CYCLES    = 18;
    localparam int SETTLE_CYCLES  = 3 * ITEM_CYCLES;
    localparam int RUNS_PER_PHASE = 85;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int TICK_MAX       = (1 << TICK_W) - 1;

    typedef struct packed {
        logic                word_valid;
        logic [7:0]          data_byte;
        logic                parity_flag;
        logic [WIDX_W-1:0]   word_index;
        logic                start_error;
        logic                packet_done;
        logic [PWORDS_W-1:0] packet_words;
        logic                overflow;
    } t_decoded;

    typedef struct {
        logic              level;
        logic [TICK_W-1:0] ticks;
        logic              eoc;
        bit                typed;
        t_decoded          want;
    } t_run;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_index;
    logic [TICK_W-1:0]   i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_line_level;
    logic [TICK_W-1:0]   i_run_ticks;
    logic                i_end_of_capture;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_word_valid;
    logic [7:0]          o_data_byte;
    logic                o_parity_flag;
    logic [WIDX_W-1:0]   o_word_index;
    logic                o_start_error;
    logic                o_packet_done;
    logic [PWORDS_W-1:0] o_packet_words;
    logic                o_overflow;

    hbs_run_length_word_decoder_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_line_level     (i_line_level),
        .i_run_ticks      (i_run_ticks),
        .i_end_of_capture (i_end_of_capture),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_word_valid     (o_word_valid),
        .o_data_byte      (o_data_byte),
        .o_parity_flag    (o_parity_flag),
        .o_word_index     (o_word_index),
        .o_start_error    (o_start_error),
        .o_packet_done    (o_packet_done),
        .o_packet_words   (o_packet_words),
        .o_overflow       (o_overflow)
    );

    // decoder state mirrored by the predictor
    logic [TICK_W-1:0]  cfg_divider = DIV_RESET;
    logic               cfg_invert  = 1'b0;
    logic [SHIFT_W-1:0] shift_reg   = '0;
    int                 bits_seen   = 0;
    int                 words_held  = 0;
    bit                 drop_seen   = 1'b0;

    t_decoded pending_results[$];

    int  mismatches    = 0;
    int  runs_sent     = 0;
    int  words_seen    = 0;
    int  start_errors  = 0;
    int  packets_seen  = 0;
    int  drops_seen    = 0;
    int  cycle_count   = 0;
    int  quiet_tx      = 0;
    bit  tx_hot        = 1'b0;

    t_run directed_runs [0:21] = '{
        '{1'b1, 15'd104,   1'b0, 1'b1, '{start_error: 1'b1, default: '0}},
        '{1'b0, 15'd0,     1'b0, 1'b1, '{start_error: 1'b1, default: '0}},
        '{1'b0, 15'd51,    1'b0, 1'b1, '{start_error: 1'b1, default: '0}},
        '{1'b0, 15'd32767, 1'b0, 1'b1, '{start_error: 1'b1, default: '0}},
        '{1'b0, 15'd2288,  1'b0, 1'b1, '{start_error: 1'b1, default: '0}},
        '{1'b1, 15'd0,     1'b1, 1'b1,
          '{start_error: 1'b1, packet_done: 1'b1, default: '0}},
        // word built from mixed runs, closed by a zero-length run
        '{1'b0, 15'd52,    1'b0, 1'b0, '0},
        '{1'b1, 15'd208,   1'b0, 1'b0, '0},
        '{1'b0, 15'd312,   1'b0, 1'b0, '0},
        '{1'b1, 15'd155,   1'b0, 1'b0, '0},
        '{1'b0, 15'd520,   1'b0, 1'b0, '0},
        '{1'b1, 15'd0,     1'b0, 1'b0, '0},
        // longest start bit, any run then closes with nothing shifted in
        '{1'b0, 15'd2184,  1'b0, 1'b0, '0},
        '{1'b0, 15'd104,   1'b0, 1'b1, '{word_valid: 1'b1, word_index: 5'd1, default: '0}},
        // one-bit start, then a maximal high run pads the word with ones
        '{1'b0, 15'd104,   1'b0, 1'b0, '0},
        '{1'b1, 15'd32767, 1'b0, 1'b1,
          '{word_valid: 1'b1, data_byte: 8'hff, parity_flag: 1'b1, word_index: 5'd2,
            default: '0}},
        // end of capture drops an open word
        '{1'b0, 15'd104,   1'b0, 1'b0, '0},
        '{1'b1, 15'd520,   1'b1, 1'b1, '{packet_done: 1'b1, packet_words: 6'd3, default: '0}},
        // word close and packet close in one run
        '{1'b0, 15'd312,   1'b0, 1'b0, '0},
        '{1'b1, 15'd1040,  1'b0, 1'b0, '0},
        '{1'b0, 15'd0,     1'b1, 1'b0, '0},
        '{1'b0, 15'd0,     1'b1, 1'b1,
          '{start_error: 1'b1, packet_done: 1'b1, default: '0}}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("hbs_run_length_word_decoder_top_test failed");
            $finish;
        end
    end

    function automatic int eff_divider();
        return (cfg_divider == '0) ? 1 : int'(cfg_divider);
    endfunction

    function automatic int max_bits();
        return (TICK_MAX + eff_divider() / 2) / eff_divider();
    endfunction

    // any tick count inside the rounding window of nbits bit times
    function automatic logic [TICK_W-1:0] ticks_for(int nbits);
        int d, lo, hi;
        d  = eff_divider();
        lo = nbits * d - d / 2;
        hi = nbits * d + (d - d / 2) - 1;
        if (lo < 0) lo = 0;
        if (hi > TICK_MAX) hi = TICK_MAX;
        return TICK_W'($urandom_range(hi, lo));
    endfunction

    function automatic bit decode_run(input logic level, input logic [TICK_W-1:0] ticks,
                                      input logic eoc, output t_decoded res);
        logic lvl;
        int   nbits;
        bit   emit;
        lvl   = level ^ cfg_invert;
        nbits = (int'(ticks) + eff_divider() / 2) / eff_divider();
        res   = '0;
        emit  = 1'b0;
        if (bits_seen == 0) begin
            if (lvl == 1'b0 && nbits > 0 && nbits < int'(START_LIM)) begin
                shift_reg = '0;
                bits_seen = nbits;
            end else begin
                res.start_error = 1'b1;
                emit = 1'b1;
            end
        end else if (nbits == 0 || bits_seen + nbits > int'(LAST_BIT)) begin
            // pad with the run's own level, then close the word
            while (bits_seen < int'(LAST_BIT)) begin
                shift_reg = {lvl, shift_reg[SHIFT_W-1:1]};
                bits_seen++;
            end
            bits_seen = 0;
            emit = 1'b1;
            if (words_held < MAX_WORDS) begin
                for (int i = 0; i < 8; i++)
                    res.data_byte[i] = shift_reg[2 * i + 1];
                res.parity_flag = shift_reg[17];
                res.word_valid  = 1'b1;
                res.word_index  = WIDX_W'(words_held);
                words_held++;
            end else begin
                res.overflow = 1'b1;
                drop_seen    = 1'b1;
            end
        end else begin
            repeat (nbits) shift_reg = {lvl, shift_reg[SHIFT_W-1:1]};
            bits_seen += nbits;
        end
        if (eoc) begin
            res.packet_done  = 1'b1;
            res.packet_words = PWORDS_W'(words_held);
            res.overflow     = res.overflow | drop_seen;
            emit       = 1'b1;
            shift_reg  = '0;
            bits_seen  = 0;
            words_held = 0;
            drop_seen  = 1'b0;
        end
        return emit;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70) return $urandom_range(3, 1);
        if (r < 95) return $urandom_range(10, 4);
        return $urandom_range(80, 30);
    endfunction

    function automatic int pick_tx_gap();
        if (quiet_tx > 0) begin
            quiet_tx--;
            return 0;
        end
        if ($urandom_range(63, 0) == 0) quiet_tx = $urandom_range(60, 20);
        if ($urandom_range(1, 0) == 1) return 0;
        return gap_len();
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic stop_tx();
        if (tx_hot) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            tx_hot = 1'b0;
        end
    endtask

    task automatic drain();
        stop_tx();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [TICK_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_BIT_DIVIDER) cfg_divider = value;
        else cfg_invert = value[0];
    endtask

    task automatic send_run(input logic level, input logic [TICK_W-1:0] ticks,
                            input logic eoc, input bit typed, input t_decoded want);
        t_decoded predicted;
        bit       emits;
        int       gap;
        gap = pick_tx_gap();
        if (gap > 0) begin
            stop_tx();
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_line_level     <= level;
        i_run_ticks      <= ticks;
        i_end_of_capture <= eoc;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tx_hot = 1'b1;
        runs_sent++;
        emits = decode_run(level, ticks, eoc, predicted);
        if (emits) pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic send_noise();
        logic [TICK_W-1:0] ticks;
        ticks = ($urandom_range(1, 0) == 1) ? TICK_W'($urandom_range(TICK_MAX, 0))
                                            : ticks_for($urandom_range(max_bits(), 0));
        send_run(1'($urandom_range(1, 0)), ticks, $urandom_range(15, 0) == 0, 1'b0, '0);
    endtask

    // fast words use the longest start so that the next run closes them
    task automatic send_word(input bit fast, input bit close_packet);
        int   nbits;
        logic level;
        logic eoc;
        bit   closes;
        if (bits_seen == 0) begin
            if (fast) nbits = int'(LAST_BIT);
            else nbits = ($urandom_range(3, 0) == 0) ? $urandom_range(21, 1) : 1;
            if (nbits > max_bits()) nbits = max_bits();
            // line level chosen so the decoded level is low
            send_run(cfg_invert, ticks_for(nbits), 1'b0, 1'b0, '0);
        end
        while (bits_seen != 0) begin
            level = 1'($urandom_range(1, 0));
            if (fast) nbits = $urandom_range(1, 0);
            else nbits = ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(4, 1);
            if (nbits > max_bits()) nbits = max_bits();
            closes = (nbits == 0) || (bits_seen + nbits > int'(LAST_BIT));
            eoc = closes ? close_packet : ($urandom_range(39, 0) == 0);
            send_run(level, ticks_for(nbits), eoc, 1'b0, '0);
        end
    endtask

    task automatic send_packet(input bit long_pkt);
        int nwords;
        int ending;
        nwords = long_pkt ? $urandom_range(MAX_WORDS + 4, MAX_WORDS + 1) : $urandom_range(6, 0);
        ending = $urandom_range(3, 0);
        for (int i = 0; i < nwords; i++) begin
            if ($urandom_range(11, 0) == 0) send_noise();
            send_word(long_pkt, (i == nwords - 1) && ending < 2);
        end
        if (nwords == 0 || ending >= 2) begin
            if (ending == 3) send_run(cfg_invert, ticks_for(0), 1'b1, 1'b0, '0);
            else send_run(~cfg_invert, TICK_W'($urandom_range(TICK_MAX, 0)), 1'b1, 1'b0, '0);
        end
    endtask

    initial begin : out_stall_gen
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= 1'b1;
            repeat (gap_len() - 1) @(negedge i_clk);
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            repeat (($urandom_range(7, 0) == 0) ? $urandom_range(300, 100)
                                                 : $urandom_range(8, 0)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_decoded want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("word_valid", 32'(want.word_valid), 32'(o_word_valid));
                check_field("data_byte", 32'(want.data_byte), 32'(o_data_byte));
                check_field("parity_flag", 32'(want.parity_flag), 32'(o_parity_flag));
                check_field("word_index", 32'(want.word_index), 32'(o_word_index));
                check_field("start_error", 32'(want.start_error), 32'(o_start_error));
                check_field("packet_done", 32'(want.packet_done), 32'(o_packet_done));
                check_field("packet_words", 32'(want.packet_words), 32'(o_packet_words));
                check_field("overflow", 32'(want.overflow), 32'(o_overflow));
                words_seen   += int'(want.word_valid);
                start_errors += int'(want.start_error);
                packets_seen += int'(want.packet_done);
                drops_seen   += int'(want.overflow & ~want.packet_done);
            end
        end
    end

    initial begin : stimulus
        int divider_plan [0:4];
        int invert_plan  [0:4];
        int phase_start;
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_BIT_DIVIDER;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_line_level     = 1'b0;
        i_run_ticks      = '0;
        i_end_of_capture = 1'b0;
        divider_plan = '{1, TICK_MAX, 0, 3, $urandom_range(300, 2)};
        invert_plan  = '{0, 1, 0, 1, $urandom_range(1, 0)};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed runs at the reset configuration
        foreach (directed_runs[k])
            send_run(directed_runs[k].level, directed_runs[k].ticks, directed_runs[k].eoc,
                     directed_runs[k].typed, directed_runs[k].want);

        for (int ph = 0; ph < 5; ph++) begin
            // reconfigure only once the decoder has gone quiet
            drain();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            write_cfg(CFG_BIT_DIVIDER, TICK_W'(divider_plan[ph]));
            write_cfg(CFG_INVERT_LEVEL, TICK_W'(invert_plan[ph]));
            phase_start = runs_sent;
            if ((ph == 0 || ph == 3) && max_bits() >= int'(LAST_BIT)) send_packet(1'b1);
            while (runs_sent - phase_start < RUNS_PER_PHASE) begin
                if ($urandom_range(7, 0) == 0) drain();
                send_packet(max_bits() >= int'(LAST_BIT) && $urandom_range(23, 0) == 0);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("runs sent: %0d over five divider and polarity settings", runs_sent);
        $display("words %0d, start errors %0d, packets closed %0d, words dropped %0d",
                 words_seen, start_errors, packets_seen, drops_seen);
        if (mismatches == 0)
            $display("hbs_run_length_word_decoder_top_test passed");
        else
            $display("hbs_run_length_word_decoder_top_test failed");
        $finish;
    end

endmodule
